>>> hw/rtl/two_sided_cache_pool_allocator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-sided cache pool allocator
// Same-cycle and next-cycle implication checks on clk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_SIDED_CACHE_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_SIDED_CACHE_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TSCPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSCPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tscpa_pkg.sv
// ---------------------------------------------------------------------------
// tscpa_pkg
// Shared constants, codes and types of the two-sided cache pool allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tscpa_pkg;

  localparam int ID_COUNT         = 256;
  localparam int PERSIST_ENTRIES  = 32;
  localparam int REGION_ADDR_BITS = 20;

  localparam int ID_W      = 8;
  localparam int SIZE_W    = 20;
  localparam int COPIES_W  = 8;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int OFF_W     = REGION_ADDR_BITS;
  localparam int ST_W      = 2;
  localparam int ST_AW     = $clog2(ID_COUNT);
  localparam int PE_AW     = $clog2(PERSIST_ENTRIES);
  localparam int PE_CW     = $clog2(PERSIST_ENTRIES + 1);
  localparam int NEED_W    = SIZE_W + COPIES_W + 1;
  localparam int SID_W     = ID_W + 1;
  localparam int GRANULE   = 16;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_SETST  = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  localparam logic [1:0] MD_TEMP    = 2'd0;
  localparam logic [1:0] MD_PERSIST = 2'd1;
  localparam logic [1:0] MD_BOTH    = 2'd2;

  localparam logic [ST_W-1:0] ST_NONE = 2'd0;
  localparam logic [ST_W-1:0] ST_PROG = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE = 2'd2;
  localparam logic [ST_W-1:0] ST_DISC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_POOL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST_POOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDS_BANKS  = 2'd2;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  localparam logic REGION_TEMP    = 1'b0;
  localparam logic REGION_PERSIST = 1'b1;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          mode;
    logic [ID_W-1:0]     item_id;
    logic [SIZE_W-1:0]   byte_size;
    logic [COPIES_W-1:0] copies;
    logic [ST_W-1:0]     new_status;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic             fail;
    logic             region;
    logic [OFF_W-1:0] offset;
    logic [ID_W-1:0]  discard_id;
    logic             last;
  } out_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic setst;
    logic tlook;
    logic walk_init;
    logic walk_step;
    logic phit;
    logic pfail;
    logic mul;
    logic palloc;
    logic rd_s0;
    logic rd_s1;
    logic talloc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] mode;
    logic       walk_hit;
    logic       walk_end;
    logic       pfit;
    logic       last_now;
  } sts_t;

endpackage

>>> hw/rtl/tscpa_ram.sv
// ---------------------------------------------------------------------------
// tscpa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tscpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tscpa_ctrl.sv
// ---------------------------------------------------------------------------
// tscpa_ctrl
// Sequencer: dispatches a request, walks the table, emits result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_sided_cache_pool_allocator_unit_assert.svh"

module tscpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tscpa_pkg::sts_t sts,
  output logic            busy,
  output logic            out_strobe,
  output tscpa_pkg::cmd_t cmd
);
  import tscpa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_PCHK = 4'd3;
  localparam logic [3:0] S_TA0  = 4'd4;
  localparam logic [3:0] S_TA1  = 4'd5;
  localparam logic [3:0] S_TA2  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_OUT;
          end
          FN_SETST: begin
            cmd.setst = 1'b1;
            state_nxt = S_OUT;
          end
          FN_LOOKUP: begin
            if (sts.mode == MD_TEMP) begin
              cmd.tlook = 1'b1;
              state_nxt = S_OUT;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          default: begin
            if (sts.mode == MD_TEMP) begin
              state_nxt = S_TA0;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = S_PCHK;
            end
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_hit) begin
          cmd.phit  = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.walk_end) begin
          if (sts.mode == MD_BOTH) begin
            cmd.tlook = 1'b1;
          end else begin
            cmd.pfail = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_PCHK: begin
        if (sts.pfit) begin
          cmd.palloc = 1'b1;
          state_nxt  = S_OUT;
        end else if (sts.mode == MD_BOTH) begin
          state_nxt = S_TA0;
        end else begin
          cmd.pfail = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_TA0: begin
        cmd.rd_s0 = 1'b1;
        state_nxt = S_TA1;
      end
      S_TA1: begin
        cmd.rd_s1 = 1'b1;
        state_nxt = S_TA2;
      end
      S_TA2: begin
        cmd.talloc = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        if (sts.last_now) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_OUT);

  `TSCPA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not go busy")
  `TSCPA_ASSERT_IMP(a_strobe_busy, out_strobe, busy, "result beat while idle")
  `TSCPA_ASSERT_NXT(a_last_idle, out_strobe && sts.last_now, !busy, "no idle after last beat")

endmodule

>>> hw/rtl/tscpa_dp.sv
// ---------------------------------------------------------------------------
// tscpa_dp
// Datapath: pool registers, slot state, status and persistent tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_sided_cache_pool_allocator_unit_assert.svh"

module tscpa_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tscpa_pkg::in_t                   in_item,
  input  logic                             cfg_we,
  input  logic [tscpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tscpa_pkg::CFG_W-1:0]      cfg_wdata,
  input  tscpa_pkg::cmd_t                  cmd,
  output tscpa_pkg::sts_t                  sts,
  output tscpa_pkg::out_t                  out_item
);
  import tscpa_pkg::*;

  localparam logic [SID_W-1:0] SID_EMPTY = {1'b1, {ID_W{1'b0}}};

  in_t                  req_r;
  logic [SIZE_W-1:0]    tpool_r, tpool_nxt;
  logic [SIZE_W-1:0]    ppool_r, ppool_nxt;
  logic                 banks_r, banks_nxt;
  logic [SID_W-1:0]     sid0_r, sid0_nxt, sid1_r, sid1_nxt;
  logic [SIZE_W-1:0]    soff1_r, soff1_nxt;
  logic                 nside_r, nside_nxt;
  logic [SIZE_W-1:0]    tfill_r, tfill_nxt;
  logic [PE_CW-1:0]     pcnt_r, pcnt_nxt;
  logic [SIZE_W-1:0]    pfill_r, pfill_nxt;
  logic [NEED_W-1:0]    need_r;
  logic [ID_COUNT-1:0]  valid_r, valid_nxt;
  logic [PE_CW-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [ST_W-1:0]      s0_r;
  logic                 n1v_r, n1v_nxt, n2v_r, n2v_nxt;
  logic [ID_W-1:0]      n1id_r, n1id_nxt, n2id_r, n2id_nxt;
  logic                 afail_r, afail_nxt, areg_r, areg_nxt;
  logic [OFF_W-1:0]     aoff_r, aoff_nxt;

  logic [ST_W-1:0]          st_rdata;
  logic [ST_AW-1:0]         st_raddr;
  logic [ID_W+SIZE_W-1:0]   pe_rdata;
  logic                     pe_re;
  logic [ID_W-1:0]          pe_id;
  logic [SIZE_W-1:0]        pe_off;
  logic [SID_W-1:0]         req_sid;
  logic                     req_id_ok;
  logic [SIZE_W+COPIES_W-1:0] prod;
  logic [NEED_W-1:0]        need_sum;
  logic [NEED_W:0]          pend_sum;
  logic [ST_W-1:0]          s1;
  logic                     oversize, side, nosel;
  logic [SID_W-1:0]         chosen;
  logic [SIZE_W-1:0]        off1;

  function automatic logic id_ok(input logic [SID_W-1:0] sid);
    id_ok = !sid[ID_W] && ({1'b0, sid[ID_W-1:0]} < SID_W'(ID_COUNT));
  endfunction

  assign req_sid   = {1'b0, req_r.item_id};
  assign req_id_ok = id_ok(req_sid);
  assign pe_id     = pe_rdata[ID_W+SIZE_W-1:SIZE_W];
  assign pe_off    = pe_rdata[SIZE_W-1:0];
  assign st_raddr  = cmd.rd_s0 ? sid0_r[ST_AW-1:0] : sid1_r[ST_AW-1:0];
  assign pe_re     = cmd.walk_step && (idx_r < pcnt_r);

  assign prod     = req_r.copies * req_r.byte_size;
  assign need_sum = {1'b0, prod} + NEED_W'(GRANULE - 1);
  assign pend_sum = {{(NEED_W+1-SIZE_W){1'b0}}, pfill_r} + {1'b0, need_r};

  assign s1 = (id_ok(sid1_r) && valid_r[sid1_r[ST_AW-1:0]]) ? st_rdata : ST_NONE;
  assign oversize = ({1'b0, req_r.byte_size} + (SIZE_W+1)'(GRANULE)) > {1'b0, tpool_r};
  assign off1 = tpool_r - req_r.byte_size - SIZE_W'(GRANULE);

  always_comb begin
    side  = 1'b0;
    nosel = 1'b0;
    if (s0_r == ST_NONE) side = 1'b0;
    else if (s1 == ST_NONE) side = 1'b1;
    else if (s0_r == ST_DISC && s1 == ST_DISC) side = nside_r;
    else if (s0_r == ST_DISC) side = 1'b0;
    else if (s1 == ST_DISC) side = 1'b1;
    else if (s0_r != ST_PROG) side = 1'b0;
    else if (s1 != ST_PROG) side = 1'b1;
    else nosel = 1'b1;
  end

  assign chosen = side ? sid1_r : sid0_r;

  tscpa_ram #(.WIDTH(ST_W), .DEPTH(ID_COUNT)) u_st_ram (
    .clk   (clk),
    .we    (cmd.setst && req_id_ok),
    .waddr (req_r.item_id[ST_AW-1:0]),
    .wdata (req_r.new_status),
    .re    (cmd.rd_s0 || cmd.rd_s1),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tscpa_ram #(.WIDTH(ID_W+SIZE_W), .DEPTH(PERSIST_ENTRIES)) u_pe_ram (
    .clk   (clk),
    .we    (cmd.palloc),
    .waddr (pcnt_r[PE_AW-1:0]),
    .wdata ({req_r.item_id, pfill_r}),
    .re    (pe_re),
    .raddr (idx_r[PE_AW-1:0]),
    .rdata (pe_rdata)
  );

  always_comb begin
    tpool_nxt = tpool_r;
    ppool_nxt = ppool_r;
    banks_nxt = banks_r;
    sid0_nxt  = sid0_r;
    sid1_nxt  = sid1_r;
    soff1_nxt = soff1_r;
    nside_nxt = nside_r;
    tfill_nxt = tfill_r;
    pcnt_nxt  = pcnt_r;
    pfill_nxt = pfill_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    n1v_nxt   = n1v_r;
    n1id_nxt  = n1id_r;
    n2v_nxt   = n2v_r;
    n2id_nxt  = n2id_r;
    afail_nxt = afail_r;
    areg_nxt  = areg_r;
    aoff_nxt  = aoff_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_POOL:    tpool_nxt = cfg_wdata[SIZE_W-1:0];
        REG_PERSIST_POOL: ppool_nxt = cfg_wdata[SIZE_W-1:0];
        REG_HOLDS_BANKS:  banks_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      afail_nxt = 1'b0;
      areg_nxt  = REGION_TEMP;
      aoff_nxt  = '0;
      n1v_nxt   = 1'b0;
      n2v_nxt   = 1'b0;
    end

    if (cmd.clear) begin
      pcnt_nxt  = '0;
      pfill_nxt = '0;
      nside_nxt = 1'b0;
      tfill_nxt = '0;
      sid0_nxt  = SID_EMPTY;
      sid1_nxt  = SID_EMPTY;
      soff1_nxt = tpool_r;
      valid_nxt = '0;
    end

    if (cmd.setst && req_id_ok) begin
      valid_nxt[req_r.item_id[ST_AW-1:0]] = 1'b1;
    end

    if (cmd.walk_init) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end

    if (cmd.walk_step) begin
      pend_nxt = pe_re;
      if (pe_re) begin
        idx_nxt = idx_r + PE_CW'(1);
      end
    end

    if (cmd.phit) begin
      afail_nxt = 1'b0;
      areg_nxt  = REGION_PERSIST;
      aoff_nxt  = OFF_W'(pe_off);
    end

    if (cmd.pfail) begin
      afail_nxt = 1'b1;
      areg_nxt  = REGION_PERSIST;
      aoff_nxt  = '0;
    end

    if (cmd.tlook) begin
      if (sid0_r == req_sid) begin
        nside_nxt = 1'b1;
        afail_nxt = 1'b0;
        aoff_nxt  = '0;
      end else if (sid1_r == req_sid) begin
        nside_nxt = 1'b0;
        afail_nxt = 1'b0;
        aoff_nxt  = OFF_W'(soff1_r);
      end else begin
        afail_nxt = 1'b1;
        aoff_nxt  = '0;
      end
      areg_nxt = REGION_TEMP;
    end

    if (cmd.palloc) begin
      pcnt_nxt  = pcnt_r + PE_CW'(1);
      pfill_nxt = pend_sum[SIZE_W-1:0];
      afail_nxt = 1'b0;
      areg_nxt  = REGION_PERSIST;
      aoff_nxt  = OFF_W'(pfill_r);
    end

    if (cmd.talloc) begin
      areg_nxt = REGION_TEMP;
      if (oversize || nosel) begin
        afail_nxt = 1'b1;
        aoff_nxt  = '0;
      end else begin
        afail_nxt = 1'b0;
        if (!chosen[ID_W]) begin
          if (id_ok(chosen)) valid_nxt[chosen[ST_AW-1:0]] = 1'b0;
          if (banks_r) begin
            n1v_nxt  = 1'b1;
            n1id_nxt = chosen[ID_W-1:0];
          end
        end
        if (!side) begin
          sid0_nxt  = req_sid;
          tfill_nxt = req_r.byte_size;
          if (soff1_r < req_r.byte_size) begin
            if (!sid1_r[ID_W]) begin
              if (id_ok(sid1_r)) valid_nxt[sid1_r[ST_AW-1:0]] = 1'b0;
              n2v_nxt  = 1'b1;
              n2id_nxt = sid1_r[ID_W-1:0];
            end
            sid1_nxt  = SID_EMPTY;
            soff1_nxt = tpool_r;
          end
          aoff_nxt = '0;
        end else begin
          soff1_nxt = off1;
          sid1_nxt  = req_sid;
          if (off1 < tfill_r) begin
            if (!sid0_r[ID_W]) begin
              if (id_ok(sid0_r)) valid_nxt[sid0_r[ST_AW-1:0]] = 1'b0;
              n2v_nxt  = 1'b1;
              n2id_nxt = sid0_r[ID_W-1:0];
            end
            sid0_nxt  = SID_EMPTY;
            tfill_nxt = '0;
          end
          aoff_nxt = OFF_W'(off1);
        end
        nside_nxt = ~side;
      end
    end

    if (cmd.emit) begin
      if (n1v_r) begin
        n1v_nxt = 1'b0;
      end else if (n2v_r) begin
        n2v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpool_r <= '0;
      ppool_r <= '0;
      banks_r <= 1'b0;
      sid0_r  <= SID_EMPTY;
      sid1_r  <= SID_EMPTY;
      soff1_r <= '0;
      nside_r <= 1'b0;
      tfill_r <= '0;
      pcnt_r  <= '0;
      pfill_r <= '0;
      valid_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      n1v_r   <= 1'b0;
      n2v_r   <= 1'b0;
    end else begin
      tpool_r <= tpool_nxt;
      ppool_r <= ppool_nxt;
      banks_r <= banks_nxt;
      sid0_r  <= sid0_nxt;
      sid1_r  <= sid1_nxt;
      soff1_r <= soff1_nxt;
      nside_r <= nside_nxt;
      tfill_r <= tfill_nxt;
      pcnt_r  <= pcnt_nxt;
      pfill_r <= pfill_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      n1v_r   <= n1v_nxt;
      n2v_r   <= n2v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.mul) begin
      need_r <= need_sum & ~NEED_W'(GRANULE - 1);
    end
    if (cmd.rd_s1) begin
      s0_r <= (id_ok(sid0_r) && valid_r[sid0_r[ST_AW-1:0]]) ? st_rdata : ST_NONE;
    end
    n1id_r  <= n1id_nxt;
    n2id_r  <= n2id_nxt;
    afail_r <= afail_nxt;
    areg_r  <= areg_nxt;
    aoff_r  <= aoff_nxt;
  end

  always_comb begin
    out_item = '0;
    if (n1v_r) begin
      out_item.kind       = KIND_NOTICE;
      out_item.discard_id = n1id_r;
    end else if (n2v_r) begin
      out_item.kind       = KIND_NOTICE;
      out_item.discard_id = n2id_r;
    end else begin
      out_item.kind   = KIND_ANSWER;
      out_item.fail   = afail_r;
      out_item.region = areg_r;
      out_item.offset = aoff_r;
      out_item.last   = 1'b1;
    end
  end

  assign sts.func     = req_r.func;
  assign sts.mode     = req_r.mode;
  assign sts.walk_hit = pend_r && (pe_id == req_r.item_id);
  assign sts.walk_end = !pend_r && (idx_r >= pcnt_r);
  assign sts.pfit     = (pcnt_r < PE_CW'(PERSIST_ENTRIES)) &&
                        (pend_sum <= (NEED_W+1)'(ppool_r));
  assign sts.last_now = !n1v_r && !n2v_r;

  `TSCPA_ASSERT_IMP(a_pcnt_range, 1'b1, pcnt_r <= PE_CW'(PERSIST_ENTRIES), "table overfilled")

endmodule

>>> hw/rtl/two_sided_cache_pool_allocator_unit.sv
// ---------------------------------------------------------------------------
// two_sided_cache_pool_allocator_unit
// Persistent bump region plus two-slot temporary region for loaded assets.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy low; busy stays high until
// the last result beat. Results come one per cycle on out_strobe (notices
// first, answer last with last set) and cannot be held off. Clear, set status
// and temporary lookup give one beat; temporary allocation gives up to 3
// beats; persistent allocation one beat, or up to 3 on fallback to the
// temporary region. Persistent lookup walks the entry table in its RAM one
// entry per cycle, up to a full table of 32 entries, and gives one beat.
`timescale 1ns / 1ps

module two_sided_cache_pool_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  tscpa_pkg::in_t                  in_item,
  output logic                            out_strobe,
  output tscpa_pkg::out_t                 out_item,
  input  logic                            cfg_we,
  input  logic [tscpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tscpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import tscpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tscpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  tscpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
